// File: hw/rtl/dtn_pkg.sv
// ----------------------------------------------------------------------------
// dtn_pkg
// Shared types, codes and elaboration helpers for the decimal text parser.
// ----------------------------------------------------------------------------
package dtn_pkg;

	localparam int DEF_MAX_DIGITS = 12;
	localparam int QDEPTH         = 2;

	// character classes produced by the front end
	localparam logic [2:0] CL_DIGIT = 3'd0;
	localparam logic [2:0] CL_PLUS  = 3'd1;
	localparam logic [2:0] CL_MINUS = 3'd2;
	localparam logic [2:0] CL_POINT = 3'd3;
	localparam logic [2:0] CL_END   = 3'd4;
	localparam logic [2:0] CL_OTHER = 3'd5;

	// parser phases
	localparam logic [1:0] PH_START   = 2'd0;
	localparam logic [1:0] PH_INT     = 2'd1;
	localparam logic [1:0] PH_FRAC    = 2'd2;
	localparam logic [1:0] PH_DISCARD = 2'd3;

	// result status codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_INVALID  = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic [2:0] cls;
		logic [3:0] digit;
	} token_t;

	function automatic logic [63:0] pow10(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

	// bits needed for the largest magnitude, 10^n - 1
	function automatic int acc_bits(input int n);
		logic [63:0] v;
		int          w;
		v = pow10(n) - 64'd1;
		w = 1;
		for (int i = 0; i < 64; i++) begin
			if ((v >> i) != 64'd0) begin
				w = i + 1;
			end
		end
		return w;
	endfunction

endpackage

// File: hw/rtl/dtn_front.sv
// ----------------------------------------------------------------------------
// dtn_front
// Accepts characters and registers them as classified tokens.
// ----------------------------------------------------------------------------
module dtn_front
	import dtn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	output logic       tok_valid,
	input  logic       tok_ready,
	output token_t     tok
);

	logic   valid_s1;
	token_t token_s1;
	token_t cls_tok;
	logic   adv;

	always_comb begin
		cls_tok.digit = 4'd0;
		priority if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			cls_tok.cls   = CL_DIGIT;
			cls_tok.digit = 4'(char_code - CH_ZERO);
		end else if (char_code == CH_NUL) begin
			cls_tok.cls = CL_END;
		end else if (char_code == CH_PLUS) begin
			cls_tok.cls = CL_PLUS;
		end else if (char_code == CH_MINUS) begin
			cls_tok.cls = CL_MINUS;
		end else if (char_code == CH_POINT) begin
			cls_tok.cls = CL_POINT;
		end else begin
			cls_tok.cls = CL_OTHER;
		end
	end

	assign adv      = !valid_s1 || tok_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			token_s1 <= cls_tok;
		end
	end

	assign tok_valid = valid_s1;
	assign tok       = token_s1;

endmodule

// File: hw/rtl/dtn_queue.sv
// ----------------------------------------------------------------------------
// dtn_queue
// Short token queue between the front end and the parser.
// ----------------------------------------------------------------------------
module dtn_queue
	import dtn_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  token_t wr_tok,
	output logic   rd_valid,
	input  logic   rd_ready,
	output token_t rd_tok
);

	localparam int PW = $clog2(QDEPTH);

	token_t            mem [QDEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != (PW+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_tok   = mem[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_tok;
		end
	end

endmodule

// File: hw/rtl/dtn_back.sv
// ----------------------------------------------------------------------------
// dtn_back
// Parser state machine with saturating digit accumulator and result register.
// ----------------------------------------------------------------------------
module dtn_back
	import dtn_pkg::*;
#(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS,
	parameter int ACC_W      = acc_bits(MAX_DIGITS),
	parameter int FRAC_W     = $clog2(MAX_DIGITS + 1)
)
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     tok_valid,
	output logic                     tok_ready,
	input  token_t                   tok,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ACC_W:0]    mantissa,
	output logic [FRAC_W-1:0]        fraction_digits,
	output logic [1:0]               status
);

	localparam logic [ACC_W+3:0] LIMIT_X = (ACC_W+4)'(pow10(MAX_DIGITS) - 64'd1);
	localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_DIGITS);

	logic [1:0]        phase_q, phase_d;
	logic              neg_q, neg_d;
	logic [ACC_W-1:0]  accum_q, accum_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic [1:0]        err_q, err_d;

	logic              out_valid_q;
	logic [ACC_W:0]    mant_q;
	logic [FRAC_W-1:0] fdig_q;
	logic [1:0]        stat_q;

	logic [ACC_W+3:0]  next_x;
	logic              over;
	logic              take;
	logic              is_end;
	logic [ACC_W:0]    mag;

	// accum*10 + d as two shifts and two adds
	assign next_x = {accum_q, 3'b000} + {2'b00, accum_q, 1'b0} + (ACC_W+4)'(tok.digit);
	assign over   = next_x > LIMIT_X;
	assign is_end = (tok.cls == CL_END);
	assign tok_ready = !is_end || !out_valid_q || out_ready;
	assign take   = tok_valid && tok_ready;
	assign mag    = {1'b0, accum_q};

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		accum_d = accum_q;
		frac_d  = frac_q;
		err_d   = err_q;
		if (is_end) begin
			phase_d = PH_START;
			neg_d   = 1'b0;
			accum_d = '0;
			frac_d  = '0;
			err_d   = ERR_NONE;
		end else begin
			unique case (phase_q)
				PH_START: begin
					unique case (tok.cls)
						CL_DIGIT: begin
							accum_d = ACC_W'(tok.digit);
							phase_d = PH_INT;
						end
						CL_PLUS:  phase_d = PH_INT;
						CL_MINUS: begin
							neg_d   = 1'b1;
							phase_d = PH_INT;
						end
						CL_POINT: phase_d = PH_FRAC;
						default: begin
							err_d   = ERR_INVALID;
							phase_d = PH_DISCARD;
						end
					endcase
				end
				PH_INT: begin
					if (tok.cls == CL_DIGIT) begin
						if (over) begin
							accum_d = LIMIT_X[ACC_W-1:0];
							if (err_q == ERR_NONE) err_d = ERR_OVERFLOW;
						end else begin
							accum_d = next_x[ACC_W-1:0];
						end
					end else if (tok.cls == CL_POINT) begin
						phase_d = PH_FRAC;
					end else begin
						err_d   = ERR_INVALID;
						accum_d = '0;
						frac_d  = '0;
						neg_d   = 1'b0;
						phase_d = PH_DISCARD;
					end
				end
				PH_FRAC: begin
					if (tok.cls == CL_DIGIT) begin
						if (over || frac_q >= FRAC_MAX) begin
							if (err_q == ERR_NONE) err_d = ERR_OVERFLOW;
						end else begin
							accum_d = next_x[ACC_W-1:0];
							frac_d  = frac_q + FRAC_W'(1);
						end
					end else begin
						err_d   = ERR_INVALID;
						accum_d = '0;
						frac_d  = '0;
						neg_d   = 1'b0;
						phase_d = PH_DISCARD;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			neg_q       <= 1'b0;
			accum_q     <= '0;
			frac_q      <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				accum_q <= accum_d;
				frac_q  <= frac_d;
				err_q   <= err_d;
			end
			if (take && is_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// invalid strings already hold a cleared, positive value
	always_ff @(posedge clk) begin
		if (take && is_end) begin
			mant_q <= neg_q ? (~mag + (ACC_W+1)'(1)) : mag;
			fdig_q <= frac_q;
			stat_q <= err_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign mantissa        = mant_q;
	assign fraction_digits = fdig_q;
	assign status          = stat_q;

endmodule

// File: hw/rtl/decimal_text_to_number_core.sv
// ----------------------------------------------------------------------------
// decimal_text_to_number_core
// ASCII decimal string parser: [+|-]digits[.digits] terminated by NUL.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/char_code) takes one character per
//   request. NUL ends a string; only then does one result request appear on
//   the output channel (out_valid/out_ready/mantissa/fraction_digits/status).
//   Value = mantissa / 10^fraction_digits. Status 0 ok, 1 invalid character
//   (value forced to zero), 2 overflow saturated.
// Throughput: one character per cycle while no NUL is held at the parser by
//   a waiting result. The per-character update is a shift-add times ten
//   plus a limit compare in the parser stage.
// Path: a taken terminator passes the front register and a queue entry,
//   then the parser loads its result into the result register.
// Stall: while a result waits, characters keep flowing until the next NUL
//   reaches the parser; the 2-entry queue and front register then fill and
//   in_ready drops.
// Reset: arst_n clears the front register, queue and parser to the start
//   phase; no result is pending after reset.
// ----------------------------------------------------------------------------
module decimal_text_to_number_core
	import dtn_pkg::*;
#(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS,
	parameter int ACC_W      = acc_bits(MAX_DIGITS),
	parameter int FRAC_W     = $clog2(MAX_DIGITS + 1)
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            char_code,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [ACC_W:0] mantissa,
	output logic [FRAC_W-1:0]     fraction_digits,
	output logic [1:0]            status
);

	// front -> queue
	logic   f_valid, f_ready;
	token_t f_tok;
	// queue -> parser
	logic   q_valid, q_ready;
	token_t q_tok;

	dtn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	dtn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_tok   (f_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_tok   (q_tok)
	);

	dtn_back #(
		.MAX_DIGITS (MAX_DIGITS),
		.ACC_W      (ACC_W),
		.FRAC_W     (FRAC_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.tok_valid       (q_valid),
		.tok_ready       (q_ready),
		.tok             (q_tok),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mantissa        (mantissa),
		.fraction_digits (fraction_digits),
		.status          (status)
	);

	// an invalid string always reports a zero value
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ERR_INVALID) |-> (mantissa == '0 && fraction_digits == '0))
		else $error("invalid result carries a nonzero value");

	// fraction count never passes the digit limit
	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fraction_digits <= FRAC_W'(MAX_DIGITS)))
		else $error("fraction digit count out of range");

	// a pending result is never overwritten: a new result needs the old one taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result dropped");

	// status code three is never produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ERR_NONE || status == ERR_INVALID || status == ERR_OVERFLOW))
		else $error("undefined status code");

endmodule
